FILE: rtl/core/pffl_pkg.sv
// Shared constants for the page frame free list: opcodes, status codes,
// configuration register indexes and the fixed page size.
// No dependencies.
`default_nettype none

package pffl_pkg;

	// fixed 4 KiB page
	localparam int PAGE_BITS = 12;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int REG_W    = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_REGION_START = 2'd0;
	localparam logic [REG_W-1:0] REG_REGION_TOP   = 2'd1;

endpackage

`default_nettype wire

FILE: rtl/core/pffl_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pffl_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pffl_ctrl.sv
// Free list sequencer: stack pointer, opcode decode, fill walk, stack RAM
// port control, result hold and output register.
// Depends on pffl_pkg.
`default_nettype none

module pffl_ctrl #(
	parameter int DEPTH     = 4096,
	parameter int ADDR_BITS = 40
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	// region configuration
	input  wire logic [ADDR_BITS-1:0]                      region_start,
	input  wire logic [ADDR_BITS-1:0]                      region_top,
	// request channel
	input  wire logic                                      in_valid,
	output logic                                           in_stall,
	input  wire logic [pffl_pkg::OP_W-1:0]                 opcode,
	input  wire logic [ADDR_BITS-1:0]                      page_address,
	// result channel
	output logic                                           out_valid,
	input  wire logic                                      out_stall,
	output logic      [ADDR_BITS-1:0]                      result_address,
	output logic      [pffl_pkg::STATUS_W-1:0]             status,
	output logic      [$clog2(DEPTH+1)-1:0]                pages_held,
	// stack RAM
	output logic                                           mem_we,
	output logic      [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
	output logic      [ADDR_BITS-pffl_pkg::PAGE_BITS-1:0]  mem_wdata,
	output logic                                           mem_re,
	output logic      [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
	input  wire logic [ADDR_BITS-pffl_pkg::PAGE_BITS-1:0]  mem_rdata
);

	localparam int PB      = pffl_pkg::PAGE_BITS;
	localparam int FRAME_W = ADDR_BITS - PB;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_HOLD = 2'd3;

	logic [1:0]                      state_q, state_d;
	logic [CNT_W-1:0]                cnt_q, cnt_d, cnt_m1;
	logic [FRAME_W:0]                fill_q, fill_d;
	logic [FRAME_W:0]                top_frame;
	logic [ADDR_BITS:0]              start_rnd;
	logic                            is_full, bad_addr, accept, out_free;

	logic                            fin_valid;
	logic [ADDR_BITS-1:0]            fin_addr;
	logic [pffl_pkg::STATUS_W-1:0]   fin_status;

	logic [ADDR_BITS-1:0]            hold_addr_q;
	logic [pffl_pkg::STATUS_W-1:0]   hold_status_q;
	logic [CNT_W-1:0]                hold_cnt_q;

	logic                            out_valid_q;
	logic [ADDR_BITS-1:0]            out_addr_q;
	logic [pffl_pkg::STATUS_W-1:0]   out_status_q;
	logic [CNT_W-1:0]                out_cnt_q;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign is_full   = (cnt_q == CNT_W'(DEPTH));
	assign bad_addr  = (page_address[PB-1:0] != '0) || (page_address < region_start)
		|| (page_address >= region_top);
	// first whole page of the region, one bit wider to catch wrap past the top
	assign start_rnd = {1'b0, region_start} + (ADDR_BITS+1)'((1 << PB) - 1);
	assign top_frame = {1'b0, region_top[ADDR_BITS-1:PB]};

	// decode, stack update and completion
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		fill_d     = fill_q;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q[IDX_W-1:0];
		mem_wdata  = page_address[ADDR_BITS-1:PB];
		mem_re     = 1'b0;
		mem_raddr  = cnt_m1[IDX_W-1:0];
		fin_valid  = 1'b0;
		fin_addr   = '0;
		fin_status = pffl_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						pffl_pkg::OP_ALLOC: begin
							if (cnt_q == '0) begin
								fin_valid  = 1'b1;
								fin_status = pffl_pkg::ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								cnt_d   = cnt_m1;
								state_d = S_READ;
							end
						end
						pffl_pkg::OP_FREE: begin
							fin_valid = 1'b1;
							if (bad_addr) begin
								fin_status = pffl_pkg::ST_BAD;
							end else if (is_full) begin
								fin_status = pffl_pkg::ST_FULL;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						pffl_pkg::OP_FILL: begin
							fill_d  = start_rnd[ADDR_BITS:PB];
							state_d = S_FILL;
						end
						default: begin
							fin_valid = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				fin_valid = 1'b1;
				fin_addr  = {mem_rdata, {PB{1'b0}}};
			end
			S_FILL: begin
				// push one page a cycle until past the top or the stack fills
				if (fill_q < top_frame) begin
					if (is_full) begin
						fin_valid  = 1'b1;
						fin_status = pffl_pkg::ST_FULL;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = fill_q[FRAME_W-1:0];
						cnt_d     = cnt_q + CNT_W'(1);
						fill_d    = fill_q + (FRAME_W+1)'(1);
					end
				end else begin
					fin_valid = 1'b1;
				end
			end
			S_HOLD: begin
				fin_valid  = 1'b1;
				fin_addr   = hold_addr_q;
				fin_status = hold_status_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin_valid) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (fin_valid && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// fill walk, held result and output word
	always_ff @(posedge clk) begin
		fill_q <= fill_d;
		if (fin_valid && !out_free && state_q != S_HOLD) begin
			hold_addr_q   <= fin_addr;
			hold_status_q <= fin_status;
			hold_cnt_q    <= cnt_d;
		end
		if (fin_valid && out_free) begin
			out_addr_q   <= fin_addr;
			out_status_q <= fin_status;
			out_cnt_q    <= (state_q == S_HOLD) ? hold_cnt_q : cnt_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_status_q;
	assign pages_held     = out_cnt_q;

endmodule

`default_nettype wire

FILE: rtl/core/page_frame_free_list_top.sv
// Top level of the page frame free list: region registers, sequencer and
// stack RAM. Depends on pffl_pkg, pffl_ram and pffl_ctrl.
`default_nettype none

// LIFO allocator of 4 KiB page frames held in a DEPTH-entry stack RAM. One
// request word is taken at a time. Free and the unused opcode finish in the
// cycle they are accepted; an alloc that finds a frame finishes once the
// registered read of the stack RAM has returned; fill pushes its pages with
// one RAM write per cycle, ending early when the stack fills.
// A finished result moves into an output register; one more finished result
// can wait inside while that register is stalled. The user must write the
// region registers only while no request is in flight; the block does not enforce it.
module page_frame_free_list_top #(
	parameter int DEPTH     = 4096,
	parameter int ADDR_BITS = 40
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pffl_pkg::REG_W-1:0]        cfg_index,
	input  wire logic [ADDR_BITS-1:0]              cfg_data,
	// request channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [pffl_pkg::OP_W-1:0]         opcode,
	input  wire logic [ADDR_BITS-1:0]              page_address,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [ADDR_BITS-1:0]              result_address,
	output logic      [pffl_pkg::STATUS_W-1:0]     status,
	output logic      [$clog2(DEPTH+1)-1:0]        pages_held
);

	localparam int FRAME_W = ADDR_BITS - pffl_pkg::PAGE_BITS;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ADDR_BITS-1:0] region_start_q, region_top_q;
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [FRAME_W-1:0]   mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;

	// region registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_top_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pffl_pkg::REG_REGION_START: region_start_q <= cfg_data;
				pffl_pkg::REG_REGION_TOP:   region_top_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pffl_ctrl #(
		.DEPTH     (DEPTH),
		.ADDR_BITS (ADDR_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.region_start   (region_start_q),
		.region_top     (region_top_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.page_address   (page_address),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_address (result_address),
		.status         (status),
		.pages_held     (pages_held),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	pffl_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// an empty alloc reports no address and an empty stack
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == pffl_pkg::ST_EMPTY)
		|-> (result_address == '0 && pages_held == '0))
		else $error("empty result carries address or count");

	// every returned address is page aligned
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_address[pffl_pkg::PAGE_BITS-1:0] == '0))
		else $error("result address not page aligned");

	// the held count never passes the stack depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pages_held <= ($clog2(DEPTH+1))'(DEPTH)))
		else $error("held page count above stack depth");

	// a full or bad status never comes with an address
	a_err_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == pffl_pkg::ST_BAD || status == pffl_pkg::ST_FULL))
		|-> (result_address == '0))
		else $error("error result carries an address");

endmodule

`default_nettype wire

FILE: tb/tb_page_frame_free_list_top.sv
// Self-checking testbench for page_frame_free_list_top: drives request and
// region words and checks every result word against a behavioral LIFO.
// Depends on pffl_pkg and the page_frame_free_list_top RTL.
`default_nettype none

module tb_page_frame_free_list_top;
	import pffl_pkg::*;

	localparam int DEPTH          = 4096;
	localparam int ADDR_BITS      = 40;
	localparam int FRAME_W        = ADDR_BITS - PAGE_BITS;
	localparam int COUNT_W        = $clog2(DEPTH + 1);
	localparam int IDX_W          = $clog2(DEPTH);
	localparam int IDLE_PCT       = 38;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int MAX_REPORTS    = 10;
	localparam int PAGE_OFFSET_MAX = (1 << PAGE_BITS) - 1;

	// opcode 3 has no meaning; the block answers with ok and changes nothing
	localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [ADDR_BITS-1:0] ADDR_MAX  = '1;
	localparam logic [63:0]          PAGE      = 64'd1 << PAGE_BITS;

	typedef struct {
		logic [ADDR_BITS-1:0] addr;
		logic [STATUS_W-1:0]  st;
		logic [COUNT_W-1:0]   count;
	} frame_result_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic [REG_W-1:0]     cfg_index    = '0;
	logic [ADDR_BITS-1:0] cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic [OP_W-1:0]      opcode       = '0;
	logic [ADDR_BITS-1:0] page_address = '0;
	logic                 out_stall    = 1'b0;
	wire logic                 cfg_ready;
	wire logic                 in_stall;
	wire logic                 out_valid;
	wire logic [ADDR_BITS-1:0] result_address;
	wire logic [STATUS_W-1:0]  status;
	wire logic [COUNT_W-1:0]   pages_held;

	// behavioral copy of the allocator
	logic [ADDR_BITS-1:0] region_start_q = '0;
	logic [ADDR_BITS-1:0] region_top_q   = '0;
	logic [FRAME_W-1:0]   held_frames [DEPTH];
	int                   held_count     = 0;
	frame_result_t        pending_results [$];

	int errors          = 0;
	int requests_sent   = 0;
	int results_seen    = 0;
	int region_settings = 0;
	int fills_sent      = 0;
	int full_replies    = 0;
	int empty_replies   = 0;
	int bad_replies     = 0;
	int quiet_cycles    = 0;
	int hold_requests   = 0;
	int hold_seen       = 0;
	int hold_left       = 0;
	bit calm            = 1'b0;

	page_frame_free_list_top #(
		.DEPTH    (DEPTH),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.page_address  (page_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_address(result_address),
		.status        (status),
		.pages_held    (pages_held)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] round_up_page(input logic [ADDR_BITS-1:0] a);
		return ({{(64 - ADDR_BITS){1'b0}}, a} + PAGE - 64'd1) & ~(PAGE - 64'd1);
	endfunction

	function automatic logic [ADDR_BITS-1:0] random_addr();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ADDR_BITS-1:0];
	endfunction

	// Work out the result word of one accepted request and queue it.
	function automatic void predict_request(input logic [OP_W-1:0] op,
			input logic [ADDR_BITS-1:0] pa);
		frame_result_t r;
		logic [63:0]   p;
		logic [63:0]   n;
		logic [63:0]   room;
		r.addr = '0;
		r.st = ST_OK;
		case (op)
			OP_ALLOC: begin
				if (held_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					held_count--;
					r.addr = {held_frames[IDX_W'(held_count)], {PAGE_BITS{1'b0}}};
				end
			end
			OP_FREE: begin
				if (pa[PAGE_BITS-1:0] != '0 || pa < region_start_q || pa >= region_top_q) begin
					r.st = ST_BAD;
				end else if (held_count >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					held_frames[IDX_W'(held_count)] = pa[ADDR_BITS-1:PAGE_BITS];
					held_count++;
				end
			end
			OP_FILL: begin
				// push ascending from the rounded-up start, clipped to the room left
				p = round_up_page(region_start_q);
				n = ({24'b0, region_top_q} >= p)
					? ({24'b0, region_top_q} - p) >> PAGE_BITS : 64'd0;
				room = 64'(DEPTH - held_count);
				if (n > room) begin
					r.st = ST_FULL;
					n = room;
				end
				for (logic [63:0] k = 0; k < n; k++) begin
					held_frames[IDX_W'(held_count)] = p[ADDR_BITS-1:PAGE_BITS];
					held_count++;
					p = p + PAGE;
				end
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(held_count);
		pending_results.push_back(r);
	endfunction

	// Offer one request word, idling first at random, and hold it until taken.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_BITS-1:0] pa);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		page_address <= pa;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(op, pa);
		requests_sent++;
		if (op == OP_FILL) fills_sent++;
	endtask

	// Drop valid and wait until every result word has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_region_reg(input logic [REG_W-1:0] idx,
			input logic [ADDR_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_REGION_START) region_start_q = value;
		else region_top_q = value;
	endtask

	task automatic set_region(input logic [ADDR_BITS-1:0] start_addr,
			input logic [ADDR_BITS-1:0] top_addr);
		wait_idle();
		write_region_reg(REG_REGION_START, start_addr);
		write_region_reg(REG_REGION_TOP, top_addr);
		cfg_valid <= 1'b0;
		region_settings++;
	endtask

	// Pick a free address: mostly a legal page, else each kind of bad one.
	function automatic logic [ADDR_BITS-1:0] free_candidate();
		logic [63:0] first;
		logic [63:0] pages;
		logic [63:0] a;
		int          kind;
		first = round_up_page(region_start_q);
		pages = ({24'b0, region_top_q} > first)
			? ({24'b0, region_top_q} - first) >> PAGE_BITS : 64'd0;
		kind = $urandom_range(99);
		if (kind < 60 && pages != 0) begin
			a = first + ((({$urandom, $urandom}) % pages) << PAGE_BITS);
		end else if (kind < 70) begin
			a = {24'b0, region_start_q} - PAGE;
			a[PAGE_BITS-1:0] = '0;
		end else if (kind < 80) begin
			a = round_up_page(region_top_q);
		end else if (kind < 90) begin
			a = {24'b0, random_addr()};
			a[PAGE_BITS-1:0] = PAGE_BITS'($urandom_range(PAGE_OFFSET_MAX, 1));
		end else begin
			a = {24'b0, random_addr()};
		end
		return a[ADDR_BITS-1:0];
	endfunction

	task automatic send_random_request(input int alloc_pct);
		int pick;
		pick = $urandom_range(99);
		if (pick < alloc_pct) begin
			send_request(OP_ALLOC, random_addr());
		end else begin
			pick = $urandom_range(99);
			if (pick < 75) send_request(OP_FREE, free_candidate());
			else if (pick < 90) send_request(OP_FILL, random_addr());
			else send_request(OP_UNUSED, random_addr());
		end
	endtask

	// Random region of a few pages anywhere in the address space; now and then empty.
	task automatic pick_random_region();
		logic [63:0] s;
		logic [63:0] t;
		s = {24'b0, random_addr()};
		if ($urandom_range(1) == 1) s[PAGE_BITS-1:0] = '0;
		t = s + (64'($urandom_range(12)) << PAGE_BITS) + 64'($urandom_range(PAGE_OFFSET_MAX));
		if ($urandom_range(7) == 0) t = s >> 1;
		if (t > {24'b0, ADDR_MAX}) t = {24'b0, ADDR_MAX};
		set_region(s[ADDR_BITS-1:0], t[ADDR_BITS-1:0]);
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch on %s at %0t: expected 0x%0h, got 0x%0h",
				field, $time, want_v, got_v);
	endtask

	// Empty stack, each bad-address kind, page zero, unaligned start, empty regions.
	task automatic test_directed_cases();
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, '0);
		send_request(OP_FILL, ADDR_MAX);
		send_request(OP_UNUSED, ADDR_MAX);
		set_region(40'h00_0000_1801, 40'h00_0000_5000);
		send_request(OP_FILL, '0);
		send_request(OP_ALLOC, '0);
		send_request(OP_FREE, 40'h00_0000_4000);
		send_request(OP_FREE, 40'h00_0000_4001);
		send_request(OP_FREE, 40'h00_0000_1000);
		send_request(OP_FREE, 40'h00_0000_5000);
		send_request(OP_FREE, {ADDR_MAX[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}});
		send_request(OP_FREE, 40'h00_0000_2000);
		repeat (5) send_request(OP_ALLOC, ADDR_MAX);
		set_region(ADDR_MAX, ADDR_MAX);
		send_request(OP_FILL, '0);
		send_request(OP_FREE, ADDR_MAX);
		set_region('0, 40'h00_0000_3000);
		send_request(OP_FREE, '0);
		send_request(OP_ALLOC, '0);
	endtask

	// Several regions; alternate growing and draining the stack.
	task automatic test_random_regions();
		for (int phase = 0; phase < 8; phase++) begin
			pick_random_region();
			repeat (90) send_random_request((phase % 2 == 1) ? 65 : 40);
		end
	endtask

	task automatic test_back_to_back();
		pick_random_region();
		calm = 1'b1;
		repeat (60) send_random_request(50);
		wait_idle();
		calm = 1'b0;
	endtask

	// Hold the result side for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		pick_random_region();
		hold_requests++;
		repeat (30) send_random_request(45);
	endtask

	// Fill the whole stack, then push onto it and take a few back.
	task automatic test_stack_overflow();
		set_region('0, ADDR_MAX);
		send_request(OP_FILL, random_addr());
		send_request(OP_FREE, 40'h00_0000_1000);
		send_request(OP_FILL, '0);
		send_request(OP_UNUSED, '0);
		repeat (3) send_request(OP_ALLOC, random_addr());
		send_request(OP_FREE, {ADDR_MAX[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}});
		send_request(OP_ALLOC, '0);
	endtask

	// Result side: random stall, a counted hold-off on request, none while calm.
	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", '0, 64'(result_address));
			end else begin
				want = pending_results.pop_front();
				if (want.st == ST_FULL) full_replies++;
				if (want.st == ST_EMPTY) empty_replies++;
				if (want.st == ST_BAD) bad_replies++;
				if (result_address !== want.addr)
					report_mismatch("result_address", 64'(want.addr), 64'(result_address));
				if (status !== want.st)
					report_mismatch("status", 64'(want.st), 64'(status));
				if (pages_held !== want.count)
					report_mismatch("pages_held", 64'(want.count), 64'(pages_held));
			end
		end
	end

	// Watchdog: end the run when no word moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_results.size());
			$display("[page_frame_free_list_top] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_regions();
		test_back_to_back();
		test_output_backpressure();
		test_stack_overflow();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("covered %0d requests and %0d results over %0d region settings",
			requests_sent, results_seen, region_settings);
		$display("fills %0d, stack-full replies %0d, empty replies %0d, bad-address replies %0d",
			fills_sent, full_replies, empty_replies, bad_replies);
		if (errors == 0) begin
			$display("[page_frame_free_list_top] OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("[page_frame_free_list_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/pffl_pkg.sv
rtl/core/pffl_ram.sv
rtl/core/pffl_ctrl.sv
rtl/core/page_frame_free_list_top.sv
tb/tb_page_frame_free_list_top.sv
